// File: design/band_magnitude_mean_std_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the band magnitude mean/std core
// Clocked property checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef BAND_MAGNITUDE_MEAN_STD_CORE_DEFINES_SVH
`define BAND_MAGNITUDE_MEAN_STD_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on clk, masked while reset is held.
`define BMMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on clk, including the reset cycles.
`define BMMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMMS_ASSERT(lbl, prop, msg)
`define BMMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/bmms_pkg.sv
// ---------------------------------------------------------------------------
// bmms_pkg
// Shared types, constants and helpers of the band magnitude mean/std core.
// ---------------------------------------------------------------------------
package bmms_pkg;

  localparam int DEF_MAX_BAND_SAMPLES = 65536;
  localparam int DEF_COEF_BITS        = 16;

  localparam int BAND_SAMPLES_W = 17;
  localparam int LAYOUT_W       = 4;
  localparam int IDX_W          = 3;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 17;
  localparam int Q8_W           = 24;
  localparam int SUM_W          = 32;
  localparam int SQSUM_W        = 48;
  localparam int SQSUM_HALF     = 24;
  localparam int MEAN_FRAC      = 8;
  localparam int VAR_FRAC       = 16;

  localparam logic [BAND_SAMPLES_W-1:0] RST_BAND_SAMPLES = 17'd16384;
  localparam logic [LAYOUT_W-1:0]       RST_NUM_SCALES   = 4'd4;
  localparam logic [LAYOUT_W-1:0]       RST_NUM_ORIENT   = 4'd6;
  localparam logic [LAYOUT_W-1:0]       LAYOUT_MAX       = 4'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BAND_SAMPLES = 2'd0,
    CFG_NUM_SCALES   = 2'd1,
    CFG_NUM_ORIENT   = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAG_RE,
    S_MAG_IM,
    S_MAG_ROOT,
    S_ACCUM,
    S_MUL_LO,
    S_MUL_HI,
    S_DIFF,
    S_VAR_ROOT,
    S_DIV_MEAN,
    S_DIV_STD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture_item;
    logic mag_sq_re;
    logic mag_root_load;
    logic root_step;
    logic accum;
    logic mul_lo;
    logic mul_hi;
    logic var_root_load;
    logic div_mean_load;
    logic div_std_load;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic div_done;
    logic band_end;
    logic out_busy;
  } status_t;

  // Zero counts as one, anything above eight saturates to eight.
  function automatic logic [LAYOUT_W-1:0] clamp_layout(input logic [LAYOUT_W-1:0] v);
    logic [LAYOUT_W-1:0] r;
    if (v == '0) begin
      r = LAYOUT_W'(1);
    end else if (v > LAYOUT_MAX) begin
      r = LAYOUT_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: design/bmms_if.sv
// ---------------------------------------------------------------------------
// bmms stream interfaces
// Valid/ready channels for coefficient input and band result output.
// ---------------------------------------------------------------------------
interface bmms_in_if #(
  parameter int COEF_BITS = bmms_pkg::DEF_COEF_BITS
) ();
  logic                        valid;
  logic                        ready;
  logic signed [COEF_BITS-1:0] real_part;
  logic signed [COEF_BITS-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface bmms_out_if ();
  logic                        valid;
  logic                        ready;
  logic [bmms_pkg::IDX_W-1:0]  scale_index;
  logic [bmms_pkg::IDX_W-1:0]  orientation_index;
  logic [bmms_pkg::Q8_W-1:0]   mean_q8;
  logic [bmms_pkg::Q8_W-1:0]   std_q8;
  logic                        last_band;

  modport source (output valid, output scale_index, output orientation_index,
                  output mean_q8, output std_q8, output last_band, input ready);
  modport sink   (input valid, input scale_index, input orientation_index,
                  input mean_q8, input std_q8, input last_band, output ready);
endinterface

// File: design/band_magnitude_mean_std_core.sv
// ---------------------------------------------------------------------------
// band_magnitude_mean_std_core
// Per coefficient: capture, square the real part, then form the magnitude with
//   the shared bit-pair square root and accumulate it; ready returns after that.
// Band end: two products, root of the variance (RW = 41 steps), then two
//   divides by n (NW = 41 steps), then emit.
// A finished result waits in the output register; the next coefficient is
//   taken meanwhile, but the next band end holds in emit until that result
//   is taken. Synchronous active-low reset clears sums and counters and
//   restores the default layout registers.
// ---------------------------------------------------------------------------
module band_magnitude_mean_std_core #(
  parameter int MAX_BAND_SAMPLES = bmms_pkg::DEF_MAX_BAND_SAMPLES,
  parameter int COEF_BITS        = bmms_pkg::DEF_COEF_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bmms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bmms_pkg::CFG_DATA_W-1:0]  cfg_data,
  bmms_in_if.sink                          in_ch,
  bmms_out_if.source                       out_ch
);

  // command and status between sequencer and datapath
  bmms_pkg::cmd_t    cmd;
  bmms_pkg::status_t sts;

  bmms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds config, sums, the shared root and divide units and the
  // output register; drop a beat never, hold the result until taken
  bmms_datapath #(
    .MAX_BAND_SAMPLES (MAX_BAND_SAMPLES),
    .COEF_BITS        (COEF_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_real    (in_ch.real_part),
    .in_imag    (in_ch.imag_part),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_scale  (out_ch.scale_index),
    .out_orient (out_ch.orientation_index),
    .out_mean   (out_ch.mean_q8),
    .out_std    (out_ch.std_q8),
    .out_last   (out_ch.last_band)
  );

endmodule

// File: design/bmms_datapath.sv
// ---------------------------------------------------------------------------
// bmms_datapath
// Config registers, accumulators, shared square root and shared divider.
// ---------------------------------------------------------------------------
module bmms_datapath #(
  parameter int MAX_BAND_SAMPLES = bmms_pkg::DEF_MAX_BAND_SAMPLES,
  parameter int COEF_BITS        = bmms_pkg::DEF_COEF_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bmms_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bmms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [COEF_BITS-1:0]                in_real,
  input  logic [COEF_BITS-1:0]                in_imag,
  input  bmms_pkg::cmd_t                      cmd,
  output bmms_pkg::status_t                   sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [bmms_pkg::IDX_W-1:0]          out_scale,
  output logic [bmms_pkg::IDX_W-1:0]          out_orient,
  output logic [bmms_pkg::Q8_W-1:0]           out_mean,
  output logic [bmms_pkg::Q8_W-1:0]           out_std,
  output logic                                out_last
);

  localparam int CW         = $clog2(MAX_BAND_SAMPLES + 1);
  localparam int MAG_IN_W   = 2 * COEF_BITS + 2;
  localparam int MAG_W      = COEF_BITS + 1;
  localparam int NQ_W       = CW + bmms_pkg::SQSUM_W;
  localparam int CMP_W      = (NQ_W > 64) ? NQ_W : 64;
  localparam int DW         = NQ_W + bmms_pkg::VAR_FRAC;
  localparam int DWE        = DW + (DW % 2);
  localparam int RW         = DWE / 2;
  localparam int REM_W      = RW + 3;
  localparam int MEAN_NUM_W = bmms_pkg::SUM_W + bmms_pkg::MEAN_FRAC;
  localparam int NW         = (MEAN_NUM_W > RW) ? MEAN_NUM_W : RW;
  localparam int RCW        = $clog2(RW + 1);
  localparam int DCW        = $clog2(NW + 1);
  localparam int MAG_SHIFT  = DWE - MAG_IN_W;
  localparam int PL_W       = CW + bmms_pkg::SQSUM_HALF;

  // configuration
  logic [bmms_pkg::BAND_SAMPLES_W-1:0] bs_r;
  logic [bmms_pkg::LAYOUT_W-1:0]       ns_r;
  logic [bmms_pkg::LAYOUT_W-1:0]       no_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= bmms_pkg::RST_BAND_SAMPLES;
      ns_r <= bmms_pkg::RST_NUM_SCALES;
      no_r <= bmms_pkg::RST_NUM_ORIENT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmms_pkg::CFG_BAND_SAMPLES: bs_r <= cfg_data;
        bmms_pkg::CFG_NUM_SCALES:   ns_r <= cfg_data[bmms_pkg::LAYOUT_W-1:0];
        bmms_pkg::CFG_NUM_ORIENT:   no_r <= cfg_data[bmms_pkg::LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] bs32;
  logic [31:0] len32;
  assign bs32  = 32'(bs_r);
  assign len32 = (bs32 == '0) ? 32'd1 :
                 (bs32 > 32'(MAX_BAND_SAMPLES)) ? 32'(MAX_BAND_SAMPLES) : bs32;

  // item capture and magnitude squares
  logic [COEF_BITS-1:0]   re_abs_r, im_abs_r;
  logic [2*COEF_BITS-1:0] mag_sq_r;
  logic [2*COEF_BITS-1:0] im_sq;
  logic [MAG_IN_W-1:0]    mag_rad;

  function automatic logic [COEF_BITS-1:0] coef_abs(input logic [COEF_BITS-1:0] v);
    return v[COEF_BITS-1] ? (~v + COEF_BITS'(1)) : v;
  endfunction

  assign im_sq   = im_abs_r * im_abs_r;
  assign mag_rad = MAG_IN_W'(mag_sq_r) + MAG_IN_W'(im_sq);

  always_ff @(posedge clk) begin
    if (cmd.capture_item) begin
      re_abs_r <= coef_abs(in_real);
      im_abs_r <= coef_abs(in_imag);
    end
    if (cmd.mag_sq_re) begin
      mag_sq_r <= re_abs_r * re_abs_r;
    end
  end

  // shared digit-by-digit square root, two radicand bits per step
  logic [DWE-1:0]   sq_rad_r;
  logic [REM_W-1:0] sq_rem_r;
  logic [RW-1:0]    sq_root_r;
  logic [RCW-1:0]   sq_cnt_r;
  logic [REM_W-1:0] rem_sh, trial;

  // accumulators and band products
  logic [bmms_pkg::SUM_W-1:0]   s_r;
  logic [bmms_pkg::SQSUM_W-1:0] q_r;
  logic [CW-1:0]                cnt_r;
  logic [PL_W-1:0]              plo_r, phi_r;
  logic [63:0]                  ss_r;
  logic [NQ_W-1:0]              nq;
  logic [CMP_W-1:0]             nq_c, ss_c, var_c;
  logic [MAG_W-1:0]             mag;
  logic [2*MAG_W-1:0]           mag_sq;

  assign rem_sh = {sq_rem_r[REM_W-3:0], sq_rad_r[DWE-1 -: 2]};
  assign trial  = REM_W'({sq_root_r, 2'b01});
  assign nq     = {phi_r, {bmms_pkg::SQSUM_HALF{1'b0}}} + NQ_W'(plo_r);
  assign nq_c   = CMP_W'(nq);
  assign ss_c   = CMP_W'(ss_r);
  assign var_c  = (nq_c >= ss_c) ? (nq_c - ss_c) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
    end else if (cmd.mag_root_load) begin
      sq_rad_r  <= DWE'(mag_rad) << MAG_SHIFT;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= RCW'(MAG_W);
    end else if (cmd.var_root_load) begin
      sq_rad_r  <= DWE'(var_c[NQ_W-1:0]) << bmms_pkg::VAR_FRAC;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_cnt_r  <= RCW'(RW);
    end else if (cmd.root_step) begin
      sq_rad_r <= sq_rad_r << 2;
      sq_cnt_r <= sq_cnt_r - RCW'(1);
      if (rem_sh >= trial) begin
        sq_rem_r  <= rem_sh - trial;
        sq_root_r <= {sq_root_r[RW-2:0], 1'b1};
      end else begin
        sq_rem_r  <= rem_sh;
        sq_root_r <= {sq_root_r[RW-2:0], 1'b0};
      end
    end
  end

  assign mag    = sq_root_r[MAG_W-1:0];
  assign mag_sq = mag * mag;

  // scale and orientation position
  logic [bmms_pkg::IDX_W-1:0]    sc_r, or_r;
  logic [bmms_pkg::LAYOUT_W-1:0] ns_eff, no_eff;
  logic                          last_o, last_s;

  assign ns_eff = bmms_pkg::clamp_layout(ns_r);
  assign no_eff = bmms_pkg::clamp_layout(no_r);
  assign last_o = ({1'b0, or_r} + bmms_pkg::LAYOUT_W'(1)) >= no_eff;
  assign last_s = ({1'b0, sc_r} + bmms_pkg::LAYOUT_W'(1)) >= ns_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r   <= '0;
      q_r   <= '0;
      cnt_r <= '0;
      sc_r  <= '0;
      or_r  <= '0;
    end else if (cmd.accum) begin
      s_r   <= s_r + bmms_pkg::SUM_W'(mag);
      q_r   <= q_r + bmms_pkg::SQSUM_W'(mag_sq);
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.emit) begin
      s_r   <= '0;
      q_r   <= '0;
      cnt_r <= '0;
      if (last_o) begin
        or_r <= '0;
        sc_r <= last_s ? '0 : (sc_r + bmms_pkg::IDX_W'(1));
      end else begin
        or_r <= or_r + bmms_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      plo_r <= PL_W'(cnt_r) * PL_W'(q_r[bmms_pkg::SQSUM_HALF-1:0]);
      ss_r  <= 64'(s_r) * 64'(s_r);
    end
    if (cmd.mul_hi) begin
      phi_r <= PL_W'(cnt_r) * PL_W'(q_r[bmms_pkg::SQSUM_W-1:bmms_pkg::SQSUM_HALF]);
    end
  end

  // shared restoring divider, one quotient bit per step, divisor is the count
  logic [NW-1:0]          dv_num_r;
  logic [CW-1:0]          dv_rem_r;
  logic [DCW-1:0]         dv_cnt_r;
  logic [bmms_pkg::Q8_W-1:0] mean_r;
  logic [CW:0]            dv_sh, dv_sub;
  logic                   dv_ge;

  assign dv_sh  = {dv_rem_r, dv_num_r[NW-1]};
  assign dv_ge  = dv_sh >= {1'b0, cnt_r};
  assign dv_sub = dv_sh - {1'b0, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_cnt_r <= '0;
    end else if (cmd.div_mean_load) begin
      dv_num_r <= NW'({s_r, {bmms_pkg::MEAN_FRAC{1'b0}}});
      dv_rem_r <= '0;
      dv_cnt_r <= DCW'(NW);
    end else if (cmd.div_std_load) begin
      mean_r   <= dv_num_r[bmms_pkg::Q8_W-1:0];
      dv_num_r <= NW'(sq_root_r);
      dv_rem_r <= '0;
      dv_cnt_r <= DCW'(NW);
    end else if (cmd.div_step) begin
      dv_cnt_r <= dv_cnt_r - DCW'(1);
      dv_num_r <= {dv_num_r[NW-2:0], dv_ge};
      dv_rem_r <= dv_ge ? dv_sub[CW-1:0] : dv_sh[CW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_scale  <= sc_r;
      out_orient <= or_r;
      out_mean   <= mean_r;
      out_std    <= dv_num_r[bmms_pkg::Q8_W-1:0];
      out_last   <= last_o && last_s;
    end
  end

  assign sts.root_done = (sq_cnt_r == '0);
  assign sts.div_done  = (dv_cnt_r == '0);
  assign sts.band_end  = (32'(cnt_r) + 32'd1) >= len32;
  assign sts.out_busy  = out_valid && !out_ready;

endmodule

// File: design/bmms_ctrl.sv
// ---------------------------------------------------------------------------
// bmms_ctrl
// Sequencer that steps the datapath through one coefficient and band end.
// ---------------------------------------------------------------------------
`include "band_magnitude_mean_std_core_defines.svh"

module bmms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bmms_pkg::status_t sts,
  output bmms_pkg::cmd_t    cmd
);

  bmms_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmms_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      bmms_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture_item = 1'b1;
          state_nxt        = bmms_pkg::S_MAG_RE;
        end
      end
      bmms_pkg::S_MAG_RE: begin
        cmd.mag_sq_re = 1'b1;
        state_nxt     = bmms_pkg::S_MAG_IM;
      end
      bmms_pkg::S_MAG_IM: begin
        cmd.mag_root_load = 1'b1;
        state_nxt         = bmms_pkg::S_MAG_ROOT;
      end
      bmms_pkg::S_MAG_ROOT: begin
        if (sts.root_done) begin
          state_nxt = bmms_pkg::S_ACCUM;
        end else begin
          cmd.root_step = 1'b1;
        end
      end
      bmms_pkg::S_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = sts.band_end ? bmms_pkg::S_MUL_LO : bmms_pkg::S_IDLE;
      end
      bmms_pkg::S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = bmms_pkg::S_MUL_HI;
      end
      bmms_pkg::S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = bmms_pkg::S_DIFF;
      end
      bmms_pkg::S_DIFF: begin
        cmd.var_root_load = 1'b1;
        state_nxt         = bmms_pkg::S_VAR_ROOT;
      end
      bmms_pkg::S_VAR_ROOT: begin
        if (sts.root_done) begin
          cmd.div_mean_load = 1'b1;
          state_nxt         = bmms_pkg::S_DIV_MEAN;
        end else begin
          cmd.root_step = 1'b1;
        end
      end
      bmms_pkg::S_DIV_MEAN: begin
        if (sts.div_done) begin
          cmd.div_std_load = 1'b1;
          state_nxt        = bmms_pkg::S_DIV_STD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      bmms_pkg::S_DIV_STD: begin
        if (sts.div_done) begin
          state_nxt = bmms_pkg::S_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      bmms_pkg::S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = bmms_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bmms_pkg::S_IDLE;
      end
    endcase
  end

  `BMMS_ASSERT(a_accept_starts_item, (state_r == bmms_pkg::S_IDLE && in_valid) |=> (state_r == bmms_pkg::S_MAG_RE), "accepted beat did not start magnitude")
  `BMMS_ASSERT(a_emit_needs_free_out, cmd.emit |-> !sts.out_busy, "result emitted over a held beat")
  `BMMS_ASSERT(a_mid_band_returns, (state_r == bmms_pkg::S_ACCUM && !sts.band_end) |=> (state_r == bmms_pkg::S_IDLE), "mid-band item did not return to idle")
  `BMMS_ASSERT_ALWAYS(a_single_load, !(cmd.mag_root_load && cmd.var_root_load), "root unit loaded twice")

endmodule

// File: tb/sv/tb_band_magnitude_mean_std_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Band magnitude mean/std core testbench
// Streams complex coefficients through the core under several band layouts,
// predicts each band's mean and standard deviation in Q.8 and checks every
// result beat against that prediction, with random gaps on both channels.
// ---------------------------------------------------------------------------
module tb_band_magnitude_mean_std_core;

  localparam int WATCHDOG_LIMIT = 12000; // cycles with no beat on either side
  localparam int SETTLE_CYCLES  = 200;   // one coefficient plus a full band end
  localparam int LONG_HOLD      = 1500;  // receiver back-pressure stretch

  typedef struct {
    bit [bmms_pkg::IDX_W-1:0] scale_index;
    bit [bmms_pkg::IDX_W-1:0] orientation_index;
    bit [bmms_pkg::Q8_W-1:0]  mean_q8;
    bit [bmms_pkg::Q8_W-1:0]  std_q8;
    bit                       last_band;
  } band_result_t;

  // Band statistics predictor and the queue of bands it expects.
  class band_stats_scoreboard;
    bit [bmms_pkg::BAND_SAMPLES_W-1:0] band_len_reg = bmms_pkg::RST_BAND_SAMPLES;
    bit [bmms_pkg::LAYOUT_W-1:0]       scales_reg   = bmms_pkg::RST_NUM_SCALES;
    bit [bmms_pkg::LAYOUT_W-1:0]       orients_reg  = bmms_pkg::RST_NUM_ORIENT;
    bit [bmms_pkg::SUM_W-1:0]          mag_sum;
    bit [bmms_pkg::SQSUM_W-1:0]        sq_sum;
    bit [bmms_pkg::BAND_SAMPLES_W-1:0] coef_count;
    bit [bmms_pkg::IDX_W-1:0]          scale_cnt;
    bit [bmms_pkg::IDX_W-1:0]          orient_cnt;
    band_result_t                      bands_due[$];
    int                                errors;

    function void write_reg(bmms_pkg::cfg_index_t idx,
                            bit [bmms_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        bmms_pkg::CFG_BAND_SAMPLES: band_len_reg = v;
        bmms_pkg::CFG_NUM_SCALES:   scales_reg   = v[bmms_pkg::LAYOUT_W-1:0];
        bmms_pkg::CFG_NUM_ORIENT:   orients_reg  = v[bmms_pkg::LAYOUT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] root128(bit [127:0] x);
      bit [63:0] r;
      bit [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (128'(c) * 128'(c) <= x) r = c;
      end
      return r;
    endfunction

    function int limit_of(int v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_coef(logic signed [15:0] re, logic signed [15:0] im);
      int           ri, ii, len, ns, no;
      bit [63:0]    mag, n;
      bit [127:0]   nq, ss, d;
      band_result_t r;
      bit           last_o, last_s;
      ri = re;
      ii = im;
      if (ri < 0) ri = -ri;
      if (ii < 0) ii = -ii;
      mag = root128(128'(ri) * 128'(ri) + 128'(ii) * 128'(ii));
      mag_sum    = mag_sum + bmms_pkg::SUM_W'(mag);
      sq_sum     = sq_sum + bmms_pkg::SQSUM_W'(mag * mag);
      coef_count = coef_count + 1'b1;
      len = limit_of(int'(band_len_reg), bmms_pkg::DEF_MAX_BAND_SAMPLES);
      ns  = limit_of(int'(scales_reg), 8);
      no  = limit_of(int'(orients_reg), 8);
      if (int'(coef_count) < len) return;
      n  = 64'(coef_count);
      nq = 128'(n) * 128'(sq_sum);
      ss = 128'(mag_sum) * 128'(mag_sum);
      // Clamp a negative variance to zero, then scale by 2^16 before the root.
      d  = (ss <= nq) ? (nq - ss) : '0;
      d  = d << bmms_pkg::VAR_FRAC;
      last_o = int'(orient_cnt) + 1 >= no;
      last_s = int'(scale_cnt) + 1 >= ns;
      r.scale_index       = scale_cnt;
      r.orientation_index = orient_cnt;
      r.mean_q8           = bmms_pkg::Q8_W'((64'(mag_sum) << bmms_pkg::MEAN_FRAC) / n);
      r.std_q8            = bmms_pkg::Q8_W'(root128(d) / n);
      r.last_band         = last_o && last_s;
      bands_due.push_back(r);
      mag_sum    = '0;
      sq_sum     = '0;
      coef_count = '0;
      if (last_o) begin
        orient_cnt = '0;
        scale_cnt  = last_s ? '0 : scale_cnt + 1'b1;
      end else begin
        orient_cnt = orient_cnt + 1'b1;
      end
    endfunction

    function void check_band(band_result_t got);
      band_result_t exp_r;
      if (bands_due.size() == 0) begin
        $error("unexpected band result: scale %0d orientation %0d",
               got.scale_index, got.orientation_index);
        errors++;
        return;
      end
      exp_r = bands_due.pop_front();
      if (got.scale_index != exp_r.scale_index) begin
        $error("scale_index: expected %0d, actual %0d", exp_r.scale_index, got.scale_index);
        errors++;
      end
      if (got.orientation_index != exp_r.orientation_index) begin
        $error("orientation_index: expected %0d, actual %0d",
               exp_r.orientation_index, got.orientation_index);
        errors++;
      end
      if (got.mean_q8 != exp_r.mean_q8) begin
        $error("mean_q8: expected %0d, actual %0d", exp_r.mean_q8, got.mean_q8);
        errors++;
      end
      if (got.std_q8 != exp_r.std_q8) begin
        $error("std_q8: expected %0d, actual %0d", exp_r.std_q8, got.std_q8);
        errors++;
      end
      if (got.last_band != exp_r.last_band) begin
        $error("last_band: expected %0d, actual %0d", exp_r.last_band, got.last_band);
        errors++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [bmms_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bmms_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  bmms_in_if  in_ch ();
  bmms_out_if out_ch ();

  band_magnitude_mean_std_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  band_stats_scoreboard sb = new();

  bit in_no_idle;          // suppress sender gaps for the current phase
  bit out_no_idle;         // suppress receiver stalls for the current phase
  int hold_requests;       // bumped by the stimulus to ask for a long hold
  int hold_served;
  int stall_left;
  int quiet_cycles;
  int coefs_sent;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.real_part = '0;
    in_ch.imag_part = '0;
    out_ch.ready    = 1'b0;
  end

  // Receiver: random stalls, plus the long hold when asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (hold_requests != hold_served) begin
      hold_served  <= hold_requests;
      out_ch.ready <= 1'b0;
      stall_left   <= LONG_HOLD;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!out_no_idle && $urandom_range(0, 99) < 25) begin
      out_ch.ready <= 1'b0;
      stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor both channels on the edge, feed the scoreboard, run the watchdog.
  always @(posedge clk) begin
    band_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_coef(in_ch.real_part, in_ch.imag_part);
      if (out_ch.valid && out_ch.ready) begin
        got.scale_index       = out_ch.scale_index;
        got.orientation_index = out_ch.orientation_index;
        got.mean_q8           = out_ch.mean_q8;
        got.std_q8            = out_ch.std_q8;
        got.last_band         = out_ch.last_band;
        sb.check_band(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function int sender_gap();
    int r;
    if (in_no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Offer one coefficient beat and hold it until accepted. Valid stays high
  // on return so back-to-back beats need no extra assignment.
  task automatic send_coef(logic signed [15:0] re, logic signed [15:0] im);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.real_part <= re;
    in_ch.imag_part <= im;
    do @(posedge clk); while (!in_ch.ready);
    coefs_sent++;
  endtask

  // Drop valid, wait for every expected band, then let the core settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.bands_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bmms_pkg::cfg_index_t idx,
                           logic [bmms_pkg::CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_layout(int len, int ns, int no);
    write_reg(bmms_pkg::CFG_BAND_SAMPLES, bmms_pkg::CFG_DATA_W'(len));
    write_reg(bmms_pkg::CFG_NUM_SCALES, bmms_pkg::CFG_DATA_W'(ns));
    write_reg(bmms_pkg::CFG_NUM_ORIENT, bmms_pkg::CFG_DATA_W'(no));
  endtask

  initial begin
    logic signed [15:0] re, im, hold_val;
    int mode, count;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-coefficient bands over the field extremes.
    set_layout(1, 2, 3);
    send_coef(-16'sd32768, -16'sd32768);
    send_coef(16'sd32767, 16'sd32767);
    send_coef(16'sd0, 16'sd0);
    send_coef(-16'sd32768, 16'sd0);
    send_coef(16'sd0, 16'sd32767);
    send_coef(-16'sd1, -16'sd1);
    send_coef(16'sd3, -16'sd4);
    drain();

    // Zero length and zero counts behave as one.
    set_layout(0, 0, 0);
    send_coef(16'sd100, -16'sd7);
    send_coef(-16'sd32768, 16'sd32767);
    drain();

    // Two-sample bands: max spread, then equal samples for a zero deviation.
    set_layout(2, 15, 15);
    send_coef(16'sd0, 16'sd0);
    send_coef(-16'sd32768, -16'sd32768);
    send_coef(16'sd32767, -16'sd32768);
    send_coef(16'sd32767, -16'sd32768);
    drain();

    // Oversized length saturates; then lower it mid-band to close the band.
    write_reg(bmms_pkg::CFG_BAND_SAMPLES, '1);
    for (int i = 0; i < 5; i++) send_coef(16'sd32767 - 16'(i * 9000), -16'sd32768);
    drain();
    write_reg(bmms_pkg::CFG_BAND_SAMPLES, bmms_pkg::CFG_DATA_W'(3));
    send_coef(16'sd12, 16'sd5);
    drain();
    // Lower the counts mid-descriptor so the counters wrap.
    write_reg(bmms_pkg::CFG_NUM_SCALES, bmms_pkg::CFG_DATA_W'(1));
    write_reg(bmms_pkg::CFG_NUM_ORIENT, bmms_pkg::CFG_DATA_W'(1));
    for (int i = 0; i < 3; i++) send_coef(-16'sd5, 16'sd9);
    drain();

    // Long receiver hold with one-coefficient bands so the core backs up.
    set_layout(1, 3, 4);
    hold_requests++;
    for (int i = 0; i < 30; i++) send_coef(16'($urandom), 16'($urandom));
    drain();

    // Random phases: new layout each time, random content styles.
    while (coefs_sent < 1600) begin
      case ($urandom_range(0, 5))
        0:       count = 1;
        1:       count = $urandom_range(2, 4);
        2:       count = $urandom_range(5, 9);
        3:       count = $urandom_range(10, 40);
        4:       count = (($urandom_range(0, 1) == 1) ? 0
                          : bmms_pkg::DEF_MAX_BAND_SAMPLES + 5);
        default: count = $urandom_range(1, 3);
      endcase
      if (count == bmms_pkg::DEF_MAX_BAND_SAMPLES + 5) count = $urandom_range(6, 20);
      set_layout(count, $urandom_range(0, 15), $urandom_range(0, 15));
      in_no_idle  = ($urandom_range(0, 3) == 0);
      out_no_idle = ($urandom_range(0, 3) == 0);
      mode     = $urandom_range(0, 3);
      hold_val = 16'($urandom);
      count    = $urandom_range(40, 140);
      for (int i = 0; i < count; i++) begin
        case (mode)
          0: begin
            re = 16'($urandom);
            im = 16'($urandom);
          end
          1: begin
            re = 16'($signed($urandom_range(0, 31)) - 16);
            im = 16'($signed($urandom_range(0, 31)) - 16);
          end
          2: begin
            re = ($urandom_range(0, 1) == 1) ? -16'sd32768 : 16'sd32767;
            im = ($urandom_range(0, 2) == 0) ? 16'sd0 : -16'sd32768;
          end
          default: begin
            re = hold_val;
            im = ($urandom_range(0, 7) == 0) ? 16'($urandom) : -hold_val;
          end
        endcase
        send_coef(re, im);
      end
      drain();
    end
    in_no_idle  = 1'b0;
    out_no_idle = 1'b0;

    if (sb.errors == 0 && sb.bands_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
